@@ rtl/core/tbc_pkg.sv @@
// Package for the tile map box collision unit: map geometry, field widths,
// controller/datapath command and status structs, and the solid tile test.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tbc_pkg;

  localparam int MAP_COLS  = 64;
  localparam int MAP_ROWS  = 64;
  localparam int COL_W     = $clog2(MAP_COLS);
  localparam int ROW_W     = $clog2(MAP_ROWS);
  localparam int MAP_DEPTH = MAP_COLS * MAP_ROWS;
  localparam int ADDR_W    = COL_W + ROW_W;

  localparam int CODE_W  = 6;
  localparam int LG_W    = 3;
  localparam int COORD_W = 16;
  localparam int SIZE_W  = 15;
  // Working width for clipping: holds x + w and the widest map extent.
  localparam int CW      = 18;

  localparam logic [LG_W-1:0] LG_RESET = LG_W'(4);

  typedef struct packed {
    logic clr;
    logic load;
    logic wr;
    logic calc;
    logic scan;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic empty;
    logic last;
    logic hit_now;
  } dp_stat_t;

  // Codes of 1 and above are solid.
  function automatic logic is_solid(input logic [CODE_W-1:0] code);
    is_solid = !code[CODE_W-1] && (|code);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/tbc_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ rtl/core/tbc_ctrl.sv @@
// Controller state machine for the tile map box collision unit.
// Depends on tbc_pkg (command and status structs).
`timescale 1ns / 1ps
`default_nettype none
module tbc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             req_type,
  input  wire tbc_pkg::dp_stat_t stat,
  output      tbc_pkg::dp_cmd_t  cmd,
  output      logic             busy,
  output      logic             out_valid,
  output      logic             out_is_query,
  output      logic             out_hit
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_CALC,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_is_query_r;
  logic   out_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      out_valid_r    <= 1'b0;
      out_is_query_r <= 1'b0;
      out_hit_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          if (stat.clr_done) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            state_r <= req_type ? ST_CALC : ST_WRITE;
          end
        end
        ST_WRITE: begin
          state_r        <= ST_IDLE;
          out_valid_r    <= 1'b1;
          out_is_query_r <= 1'b0;
          out_hit_r      <= 1'b0;
        end
        ST_CALC: begin
          if (stat.empty) begin
            state_r        <= ST_IDLE;
            out_valid_r    <= 1'b1;
            out_is_query_r <= 1'b1;
            out_hit_r      <= 1'b0;
          end else begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (stat.hit_now) begin
            state_r        <= ST_IDLE;
            out_valid_r    <= 1'b1;
            out_is_query_r <= 1'b1;
            out_hit_r      <= 1'b1;
          end else if (stat.last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r        <= ST_IDLE;
          out_valid_r    <= 1'b1;
          out_is_query_r <= 1'b1;
          out_hit_r      <= stat.hit_now;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd      = '0;
    cmd.clr  = (state_r == ST_CLEAR);
    cmd.load = (state_r == ST_IDLE) && start;
    cmd.wr   = (state_r == ST_WRITE);
    cmd.calc = (state_r == ST_CALC);
    cmd.scan = (state_r == ST_SCAN);
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_query = out_is_query_r;
  assign out_hit      = out_hit_r;

endmodule
`default_nettype wire

@@ rtl/core/tbc_datapath.sv @@
// Datapath: request registers, tile size register, rectangle clipping,
// tile scan counters and the tile map memory.
// Depends on tbc_pkg and tbc_ram.
`timescale 1ns / 1ps
`default_nettype none
module tbc_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire tbc_pkg::dp_cmd_t                    cmd,
  output      tbc_pkg::dp_stat_t                   stat,
  input  wire logic                                cfg_we,
  input  wire logic        [tbc_pkg::LG_W-1:0]     cfg_data,
  input  wire logic        [tbc_pkg::COL_W-1:0]    tile_col,
  input  wire logic        [tbc_pkg::ROW_W-1:0]    tile_row,
  input  wire logic signed [tbc_pkg::CODE_W-1:0]   tile_code,
  input  wire logic signed [tbc_pkg::COORD_W-1:0]  box_x,
  input  wire logic signed [tbc_pkg::COORD_W-1:0]  box_y,
  input  wire logic        [tbc_pkg::SIZE_W-1:0]   box_w,
  input  wire logic        [tbc_pkg::SIZE_W-1:0]   box_h
);

  localparam int CW = tbc_pkg::CW;

  logic [tbc_pkg::LG_W-1:0]           lg_r;
  logic [tbc_pkg::COL_W-1:0]          col_in_r;
  logic [tbc_pkg::ROW_W-1:0]          row_in_r;
  logic [tbc_pkg::CODE_W-1:0]         code_r;
  logic signed [tbc_pkg::COORD_W-1:0] box_x_r;
  logic signed [tbc_pkg::COORD_W-1:0] box_y_r;
  logic [tbc_pkg::SIZE_W-1:0]         box_w_r;
  logic [tbc_pkg::SIZE_W-1:0]         box_h_r;

  logic [tbc_pkg::ADDR_W-1:0] clr_addr_r;
  logic [tbc_pkg::COL_W-1:0]  col_r, sx_r, ex_r;
  logic [tbc_pkg::ROW_W-1:0]  row_r, ey_r;
  logic                       rd_valid_r;
  logic                       hit_r;

  logic signed [CW-1:0] map_w, map_h;
  logic signed [CW-1:0] xs, ys, left, top, right_raw, bot_raw, right, bottom;
  logic [CW-1:0]        sx_full, sy_full, ex_full, ey_full;
  logic                 empty;

  logic                        ram_we;
  logic [tbc_pkg::ADDR_W-1:0]  ram_wr_addr;
  logic [tbc_pkg::CODE_W-1:0]  ram_wr_data;
  logic [tbc_pkg::CODE_W-1:0]  ram_rd_data;
  logic                        in_map;
  logic                        col_end;
  logic                        solid_rd;

  // Clip the rectangle to the map and find the covered tile span.
  always_comb begin
    map_w     = $signed(CW'(tbc_pkg::MAP_COLS) << lg_r);
    map_h     = $signed(CW'(tbc_pkg::MAP_ROWS) << lg_r);
    xs        = CW'(box_x_r);
    ys        = CW'(box_y_r);
    left      = xs[CW-1] ? '0 : xs;
    top       = ys[CW-1] ? '0 : ys;
    right_raw = xs + $signed(CW'(box_w_r));
    bot_raw   = ys + $signed(CW'(box_h_r));
    right     = (right_raw > map_w) ? map_w : right_raw;
    bottom    = (bot_raw > map_h) ? map_h : bot_raw;
    empty     = (right <= left) || (bottom <= top);
    sx_full   = CW'(left) >> lg_r;
    sy_full   = CW'(top) >> lg_r;
    ex_full   = CW'(right - CW'(1)) >> lg_r;
    ey_full   = CW'(bottom - CW'(1)) >> lg_r;
  end

  assign col_end  = (col_r == ex_r);
  assign solid_rd = rd_valid_r && tbc_pkg::is_solid(ram_rd_data);
  assign in_map   = ({1'b0, col_in_r} < (tbc_pkg::COL_W + 1)'(tbc_pkg::MAP_COLS)) &&
                    ({1'b0, row_in_r} < (tbc_pkg::ROW_W + 1)'(tbc_pkg::MAP_ROWS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lg_r       <= tbc_pkg::LG_RESET;
      clr_addr_r <= '0;
      rd_valid_r <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        lg_r <= cfg_data;
      end
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + tbc_pkg::ADDR_W'(1);
      end
      rd_valid_r <= cmd.scan;
      if (cmd.calc) begin
        hit_r <= 1'b0;
      end else if (solid_rd) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_in_r <= tile_col;
      row_in_r <= tile_row;
      code_r   <= tile_code;
      box_x_r  <= box_x;
      box_y_r  <= box_y;
      box_w_r  <= box_w;
      box_h_r  <= box_h;
    end
    if (cmd.calc) begin
      sx_r  <= sx_full[tbc_pkg::COL_W-1:0];
      ex_r  <= ex_full[tbc_pkg::COL_W-1:0];
      ey_r  <= ey_full[tbc_pkg::ROW_W-1:0];
      col_r <= sx_full[tbc_pkg::COL_W-1:0];
      row_r <= sy_full[tbc_pkg::ROW_W-1:0];
    end else if (cmd.scan) begin
      if (col_end) begin
        col_r <= sx_r;
        row_r <= row_r + tbc_pkg::ROW_W'(1);
      end else begin
        col_r <= col_r + tbc_pkg::COL_W'(1);
      end
    end
  end

  // Clearing pass owns the write port after reset; tile writes use it after.
  always_comb begin
    ram_we      = cmd.clr || (cmd.wr && in_map);
    ram_wr_addr = cmd.clr ? clr_addr_r : {row_in_r, col_in_r};
    ram_wr_data = cmd.clr ? '0 : code_r;
  end

  tbc_ram #(
    .WIDTH (tbc_pkg::CODE_W),
    .DEPTH (tbc_pkg::MAP_DEPTH)
  ) u_map (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.scan),
    .rd_addr ({row_r, col_r}),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    stat          = '0;
    stat.clr_done = cmd.clr && (&clr_addr_r);
    stat.empty    = empty;
    stat.last     = col_end && (row_r == ey_r);
    stat.hit_now  = hit_r || solid_rd;
  end

endmodule
`default_nettype wire

@@ rtl/core/tilemap_box_collision_unit.sv @@
// Tile map box collision unit, top level: controller, datapath and tile map.
// Depends on tbc_pkg, tbc_ctrl, tbc_datapath (and through it tbc_ram).
//
// The unit holds a 64 by 64 map of 6-bit signed tile codes. A request is
// taken when start is high and busy is low. A tile write request stores one
// code (writes off the map are dropped but still acknowledged) and shows its
// result after the write state. A query request clips the pixel box to the
// map in the calc state, then reads the covered tiles from the map memory
// one per cycle, row by row, stopping at the first solid tile (code 1 or
// more); an empty overlap shows its result straight after the calc state.
// The single read port of the map memory sets the scan rate.
// Every request yields exactly one result, shown for one cycle with out_valid
// high; the receiver cannot stall it, so latch it on that cycle. After reset
// the unit clears the map, one entry a cycle, and holds busy high until the
// whole map is cleared. The tile size register is written through
// cfg_valid/cfg_ready, which is always ready; write it only while the unit
// is idle.
`timescale 1ns / 1ps
`default_nettype none
module tilemap_box_collision_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output      logic                                busy,
  input  wire logic                                in_req_type,
  input  wire logic        [tbc_pkg::COL_W-1:0]    in_tile_col,
  input  wire logic        [tbc_pkg::ROW_W-1:0]    in_tile_row,
  input  wire logic signed [tbc_pkg::CODE_W-1:0]   in_tile_code,
  input  wire logic signed [tbc_pkg::COORD_W-1:0]  in_box_x,
  input  wire logic signed [tbc_pkg::COORD_W-1:0]  in_box_y,
  input  wire logic        [tbc_pkg::SIZE_W-1:0]   in_box_w,
  input  wire logic        [tbc_pkg::SIZE_W-1:0]   in_box_h,
  output      logic                                out_valid,
  output      logic                                out_is_query,
  output      logic                                out_hit,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic        [tbc_pkg::LG_W-1:0]     cfg_tile_size_log2
);

  tbc_pkg::dp_cmd_t  cmd;
  tbc_pkg::dp_stat_t stat;

  // Register writes are accepted at once.
  assign cfg_ready = 1'b1;

  tbc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .req_type     (in_req_type),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_is_query (out_is_query),
    .out_hit      (out_hit)
  );

  tbc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_tile_size_log2),
    .tile_col  (in_tile_col),
    .tile_row  (in_tile_row),
    .tile_code (in_tile_code),
    .box_x     (in_box_x),
    .box_y     (in_box_y),
    .box_w     (in_box_w),
    .box_h     (in_box_h)
  );

  // An accepted request always makes the unit busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the unit busy");

  // A result is shown only as the unit returns to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // One strobe per request: never two in a row.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // Write acknowledges never report a hit.
  a_write_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_query) |-> !out_hit)
    else $error("write acknowledge reports a hit");

endmodule
`default_nettype wire
